[hw/rtl/bsfe_pkg.sv]
// shared constants and types for the byte stuffing frame encoder
// no dependencies; used by every other file of the block but bsfe_if
`default_nettype none

package bsfe_pkg;

  localparam logic [7:0] StartCode = 8'hC0;
  localparam logic [7:0] EscCode   = 8'hDB;
  localparam logic [7:0] EscStart  = 8'hDC;
  localparam logic [7:0] EscEsc    = 8'hDD;
  localparam logic [7:0] StopCode  = 8'hDB;

  localparam int unsigned QueueDepth = 2;

  // one classified payload byte, as handed from front to back
  typedef struct packed {
    logic       with_start;
    logic       escaped;
    logic [7:0] data_byte;
    logic       with_stop;
  } desc_t;

endpackage

`default_nettype wire

[hw/rtl/bsfe_if.sv]
// valid/ready channel interfaces for payload bytes and line bytes
// no dependencies
`default_nettype none

interface bsfe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       frame_last;

  modport source (output valid, output payload_byte, output frame_last, input ready);
  modport sink   (input valid, input payload_byte, input frame_last, output ready);
endinterface

interface bsfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_byte;
  logic       burst_last;
  logic       frame_done;

  modport source (output valid, output line_byte, output burst_last, output frame_done,
                  input ready);
  modport sink   (input valid, input line_byte, input burst_last, input frame_done,
                  output ready);
endinterface

`default_nettype wire

[hw/rtl/byte_stuffing_frame_encoder_core.sv]
// top level of the byte stuffing frame encoder: front, queue and back
// depends on bsfe_pkg, bsfe_if, bsfe_front, bsfe_queue, bsfe_back
//
//   channel | dir | payload                                  | handshake
//   in_i    | in  | payload_byte[7:0], frame_last            | valid/ready
//   out_o   | out | line_byte[7:0], burst_last, frame_done   | valid/ready
//
// the back end sends one line byte per cycle while out_o is not stalled; an
// input byte gives 1 to 5 line bytes (start byte, escape pair, stop pair);
// its first line byte passes a queue entry, cur_q and obyte_q on its way out
// the queue lets the front take bytes while the back is stalled or busy
// asynchronous active-low reset empties the queue and re-arms the start byte
`default_nettype none

module byte_stuffing_frame_encoder_core #(
  parameter int unsigned QueueDepth = bsfe_pkg::QueueDepth
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  bsfe_in_if.sink    in_i,
  bsfe_out_if.source out_o
);

  bsfe_pkg::desc_t push_desc, pop_desc;
  logic            push_valid, push_ready, pop_valid, pop_ready;

  bsfe_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_desc_o  (push_desc),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready)
  );

  bsfe_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_desc_i  (push_desc),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .pop_desc_o   (pop_desc),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready)
  );

  bsfe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_desc_i  (pop_desc),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

[hw/rtl/bsfe_front.sv]
// front end: accepts payload bytes, tracks frame position and classifies
// depends on bsfe_pkg and bsfe_in_if
`default_nettype none

module bsfe_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  bsfe_in_if.sink            in_i,
  output bsfe_pkg::desc_t    push_desc_o,
  output logic               push_valid_o,
  input  wire logic          push_ready_i
);

  logic inside_q, inside_d;
  logic accept;

  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid;
  assign accept       = in_i.valid && push_ready_i;

  always_comb begin
    push_desc_o.with_start = !inside_q;
    push_desc_o.with_stop  = in_i.frame_last;
    push_desc_o.escaped    = (in_i.payload_byte == bsfe_pkg::StartCode) ||
                             (in_i.payload_byte == bsfe_pkg::EscCode);
    // escaped bytes keep only their second line byte here
    if (in_i.payload_byte == bsfe_pkg::StartCode) begin
      push_desc_o.data_byte = bsfe_pkg::EscStart;
    end else if (in_i.payload_byte == bsfe_pkg::EscCode) begin
      push_desc_o.data_byte = bsfe_pkg::EscEsc;
    end else begin
      push_desc_o.data_byte = in_i.payload_byte;
    end
  end

  always_comb begin
    inside_d = inside_q;
    if (accept) begin
      inside_d = !in_i.frame_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
    end else begin
      inside_q <= inside_d;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/bsfe_queue.sv]
// short register queue of classified bytes between front and back
// depends on bsfe_pkg
`default_nettype none

module bsfe_queue #(
  parameter int unsigned Depth = bsfe_pkg::QueueDepth
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire bsfe_pkg::desc_t push_desc_i,
  input  wire logic            push_valid_i,
  output logic                 push_ready_o,
  output bsfe_pkg::desc_t      pop_desc_o,
  output logic                 pop_valid_o,
  input  wire logic            pop_ready_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  bsfe_pkg::desc_t entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_desc_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_desc_i;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/bsfe_back.sv]
// back end: expands one classified byte into its line bytes, one per cycle unless out_o stalls
// depends on bsfe_pkg and bsfe_out_if
`default_nettype none

module bsfe_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire bsfe_pkg::desc_t pop_desc_i,
  input  wire logic            pop_valid_i,
  output logic                 pop_ready_o,
  bsfe_out_if.source           out_o
);

  typedef enum logic [2:0] {
    PhStart,
    PhEsc,
    PhData,
    PhStop1,
    PhStop2
  } phase_e;

  logic            busy_q, busy_d;
  phase_e          phase_q, phase_d;
  bsfe_pkg::desc_t cur_q, cur_d;
  logic            ovalid_q, ovalid_d;
  logic [7:0]      obyte_q, obyte_d;
  logic            olast_q, olast_d;
  logic            odone_q, odone_d;

  logic       load, emit, final_ph, take;
  phase_e     next_ph, first_ph;
  logic [7:0] ph_byte;

  assign out_o.valid      = ovalid_q;
  assign out_o.line_byte  = obyte_q;
  assign out_o.burst_last = olast_q;
  assign out_o.frame_done = odone_q;

  always_comb begin
    load        = !ovalid_q || out_o.ready;
    emit        = busy_q && load;
    final_ph    = (phase_q == PhStop2) || ((phase_q == PhData) && !cur_q.with_stop);
    pop_ready_o = !busy_q || (emit && final_ph);
    take        = pop_valid_i && pop_ready_o;

    if (pop_desc_i.with_start) begin
      first_ph = PhStart;
    end else if (pop_desc_i.escaped) begin
      first_ph = PhEsc;
    end else begin
      first_ph = PhData;
    end

    unique case (phase_q)
      PhStart: begin
        next_ph = cur_q.escaped ? PhEsc : PhData;
        ph_byte = bsfe_pkg::StartCode;
      end
      PhEsc: begin
        next_ph = PhData;
        ph_byte = bsfe_pkg::EscCode;
      end
      PhData: begin
        next_ph = PhStop1;
        ph_byte = cur_q.data_byte;
      end
      PhStop1: begin
        next_ph = PhStop2;
        ph_byte = bsfe_pkg::StopCode;
      end
      PhStop2: begin
        next_ph = PhStart;
        ph_byte = bsfe_pkg::StopCode;
      end
      default: begin
        next_ph = PhStart;
        ph_byte = bsfe_pkg::StopCode;
      end
    endcase
  end

  always_comb begin
    busy_d   = busy_q;
    phase_d  = phase_q;
    cur_d    = cur_q;
    ovalid_d = ovalid_q;
    obyte_d  = obyte_q;
    olast_d  = olast_q;
    odone_d  = odone_q;

    if (load) begin
      ovalid_d = emit;
    end
    if (emit) begin
      obyte_d = ph_byte;
      olast_d = final_ph;
      odone_d = (phase_q == PhStop2);
      phase_d = next_ph;
      if (final_ph) begin
        busy_d = 1'b0;
      end
    end
    // next item enters on the same edge the last byte of this one leaves
    if (take) begin
      busy_d  = 1'b1;
      cur_d   = pop_desc_i;
      phase_d = first_ph;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      phase_q  <= PhStart;
      ovalid_q <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      phase_q  <= phase_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    obyte_q <= obyte_d;
    olast_q <= olast_d;
    odone_q <= odone_d;
  end

endmodule

`default_nettype wire

[hw/rtl/bsfe_checker.sv]
// port-level checks for the byte stuffing frame encoder, bound to the top
// depends on bsfe_pkg and byte_stuffing_frame_encoder_core
`default_nettype none

module bsfe_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] line_byte_i,
  input wire logic       burst_last_i,
  input wire logic       frame_done_i
);

  // a stalled line byte stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("line byte withdrawn while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(line_byte_i) && $stable(burst_last_i) && $stable(frame_done_i))
    else $error("line payload changed while stalled");

  // the closing stop byte ends its burst
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && frame_done_i |-> burst_last_i && (line_byte_i == bsfe_pkg::StopCode))
    else $error("frame close without stop byte at burst end");

  // a frame close is the second of two stop bytes in a row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && frame_done_i |->
      $past(out_valid_i) && $past(line_byte_i) == bsfe_pkg::StopCode)
    else $error("frame close not preceded by stop byte");

  // nothing offered once a clock edge has seen reset
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_i)
    else $error("line byte offered during reset");

endmodule

bind byte_stuffing_frame_encoder_core bsfe_checker u_bsfe_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .line_byte_i  (out_o.line_byte),
  .burst_last_i (out_o.burst_last),
  .frame_done_i (out_o.frame_done)
);

`default_nettype wire
